>>> hw/rtl/mwte_pkg.sv
// ----------------------------------------------------------------------------
// mwte_pkg
// Shared types and constants of the winding thermal estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package mwte_pkg;

    localparam int TEMP_FRAC_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam int MUL_W      = 32;
    localparam int CUR_W      = 16;
    localparam int RES_W      = 16;
    localparam int ISQ_W      = 32;
    localparam int AMB_W      = 16;
    localparam int COND_W     = 24;
    localparam int GAIN_W     = 32;
    localparam int CEIL_W     = 16;
    localparam int TEMP_W     = 17;
    localparam int LOSS_W     = 24;
    localparam int LOSS_SHIFT = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

    localparam logic [AMB_W-1:0]  AMBIENT_RESET     = 16'd6400;
    localparam logic [COND_W-1:0] CONDUCTANCE_RESET = 24'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET        = 32'd42950;
    localparam logic [CEIL_W-1:0] CEILING_RESET     = 16'd51200;

    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONDUCTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING     = 2'd3;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_RESET  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ISQ_W-1:0]  isq;
        logic [RES_W-1:0]  rs;
    } cmd_t;

    typedef struct packed {
        logic [AMB_W-1:0]  ambient;
        logic [COND_W-1:0] conductance;
        logic [GAIN_W-1:0] gain;
        logic [CEIL_W-1:0] ceiling;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/mwte_front.sv
// ----------------------------------------------------------------------------
// mwte_front
// Takes requests, classifies them and forms the current square sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mwte_front
    import mwte_pkg::*;
(
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             kind,
    input  wire logic [CUR_W-1:0] phase_d_current,
    input  wire logic [CUR_W-1:0] phase_q_current,
    input  wire logic [RES_W-1:0] winding_resistance,
    input  wire logic             q_full,
    output logic                  q_push,
    output cmd_t                  q_data
);

    logic signed [ISQ_W-1:0] sq_d;
    logic signed [ISQ_W-1:0] sq_q;

    assign sq_d = ISQ_W'($signed(phase_d_current)) * ISQ_W'($signed(phase_d_current));
    assign sq_q = ISQ_W'($signed(phase_q_current)) * ISQ_W'($signed(phase_q_current));

    assign in_stall    = q_full;
    assign q_push      = in_valid && !q_full;
    assign q_data.kind = kind;
    assign q_data.isq  = (kind == KIND_RESET) ? '0 : (ISQ_W'(sq_d) + ISQ_W'(sq_q));
    assign q_data.rs   = winding_resistance;

endmodule

`default_nettype wire

>>> hw/rtl/mwte_queue.sv
// ----------------------------------------------------------------------------
// mwte_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mwte_queue
    import mwte_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      wr_data,
    input  wire logic pop,
    output cmd_t      rd_data,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mwte_core.sv
// ----------------------------------------------------------------------------
// mwte_core
// Sequenced loss and forward Euler update on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mwte_core
    import mwte_pkg::*;
#(
    parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  cfg_t                   cfg,
    input  wire logic              q_empty,
    input  cmd_t                   q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [TEMP_W-1:0]      winding_temperature,
    output logic [LOSS_W-1:0]      copper_loss_power
);

    localparam int F       = TEMP_FRAC_BITS;
    localparam int ACC_W   = F + 17;
    localparam int DIFF_W  = F + 18;
    localparam int DISS_W  = F + 25;
    localparam int DELTA_W = F + 26;
    localparam int NET_W   = F + 27;
    localparam int SUM_W   = F + 28;
    localparam int MAG_W   = 2 * MUL_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int WIDE_W  = 3 * MUL_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOSS   = 4'd1;
    localparam logic [3:0] ST_MAG1   = 4'd2;
    localparam logic [3:0] ST_ML1    = 4'd3;
    localparam logic [3:0] ST_MH1    = 4'd4;
    localparam logic [3:0] ST_SUM1   = 4'd5;
    localparam logic [3:0] ST_NET    = 4'd6;
    localparam logic [3:0] ST_MAG2   = 4'd7;
    localparam logic [3:0] ST_ML2    = 4'd8;
    localparam logic [3:0] ST_MH2    = 4'd9;
    localparam logic [3:0] ST_SUM2   = 4'd10;
    localparam logic [3:0] ST_ACC    = 4'd11;
    localparam logic [3:0] ST_FINISH = 4'd12;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;

    logic               kind_reg;
    logic [ISQ_W-1:0]   isq_reg;
    logic [RES_W-1:0]   rs_reg;
    logic [LOSS_W-1:0]  loss_reg;
    logic [DIFF_W-1:0]  diff_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  plo_reg;
    logic [PROD_W-1:0]  phi_reg;
    logic [DISS_W-1:0]  diss_reg;
    logic [NET_W-1:0]   net_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               out_valid_reg;
    logic [TEMP_W-1:0]  out_temp_reg;
    logic [LOSS_W-1:0]  out_loss_reg;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [LOSS_W-1:0]  loss_next;
    logic [SUM_W-1:0]   lo_sum;
    logic [SUM_W-1:0]   hi_sum;
    logic [DIFF_W-1:0]  diff_next;
    logic [DIFF_W-1:0]  diff_abs;
    logic [NET_W-1:0]   loss_shift;
    logic [NET_W-1:0]   net_next;
    logic [NET_W-1:0]   net_abs;
    logic [WIDE_W-1:0]  wide_sum;
    logic [SUM_W-1:0]   acc_sx;
    logic [SUM_W-1:0]   delta_x;
    logic [SUM_W-1:0]   sum_next;
    logic [SUM_W-1:0]   lower_clamped;
    logic [SUM_W-1:0]   clamped;
    logic [ACC_W-1:0]   acc_new;
    logic               slot_free;

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_LOSS:
            begin
                mul_a = isq_reg;
                mul_b = MUL_W'(rs_reg);
            end
            ST_ML1:
            begin
                mul_a = mag_reg[MUL_W-1:0];
                mul_b = MUL_W'(cfg.conductance);
            end
            ST_MH1:
            begin
                mul_a = mag_reg[MAG_W-1:MUL_W];
                mul_b = MUL_W'(cfg.conductance);
            end
            ST_ML2:
            begin
                mul_a = mag_reg[MUL_W-1:0];
                mul_b = cfg.gain;
            end
            ST_MH2:
            begin
                mul_a = mag_reg[MAG_W-1:MUL_W];
                mul_b = cfg.gain;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign loss_next = (mul_p[PROD_W-1:LOSS_SHIFT+LOSS_W] != '0) ? LOSS_MAX
                                                                 : mul_p[LOSS_SHIFT +: LOSS_W];

    // clamp bounds in accumulator scale
    assign lo_sum = {{(SUM_W-AMB_W-F){cfg.ambient[AMB_W-1]}}, cfg.ambient, {F{1'b0}}};
    assign hi_sum = {{(SUM_W-CEIL_W-F){1'b0}}, cfg.ceiling, {F{1'b0}}};

    assign diff_next = {acc_reg[ACC_W-1], acc_reg} - lo_sum[DIFF_W-1:0];
    assign diff_abs  = diff_reg[DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;

    assign wide_sum = {{MUL_W{1'b0}}, plo_reg} + {phi_reg, {MUL_W{1'b0}}};

    assign loss_shift = NET_W'({loss_reg, {F{1'b0}}});
    assign net_next   = neg_reg ? (loss_shift + NET_W'(diss_reg))
                                : (loss_shift - NET_W'(diss_reg));
    assign net_abs    = net_reg[NET_W-1] ? (~net_reg + 1'b1) : net_reg;

    assign acc_sx   = {{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
    assign delta_x  = {{(SUM_W-DELTA_W){1'b0}}, delta_reg};
    assign sum_next = neg_reg ? (acc_sx - delta_x) : (acc_sx + delta_x);

    // ceiling applied last so it wins over ambient
    assign lower_clamped = ($signed(sum_reg) < $signed(lo_sum)) ? lo_sum : sum_reg;
    assign clamped       = ($signed(lower_clamped) > $signed(hi_sum)) ? hi_sum : lower_clamped;
    assign acc_new       = (kind_reg == KIND_RESET) ? lo_sum[ACC_W-1:0] : clamped[ACC_W-1:0];

    assign slot_free = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_data.kind == KIND_RESET) ? ST_FINISH : ST_LOSS;
                end
            end
            ST_LOSS:   state_next = ST_MAG1;
            ST_MAG1:   state_next = ST_ML1;
            ST_ML1:    state_next = ST_MH1;
            ST_MH1:    state_next = ST_SUM1;
            ST_SUM1:   state_next = ST_NET;
            ST_NET:    state_next = ST_MAG2;
            ST_MAG2:   state_next = ST_ML2;
            ST_ML2:    state_next = ST_MH2;
            ST_MH2:    state_next = ST_SUM2;
            ST_SUM2:   state_next = ST_ACC;
            ST_ACC:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    kind_reg <= q_data.kind;
                    isq_reg  <= q_data.isq;
                    rs_reg   <= q_data.rs;
                end
            end
            ST_LOSS:
            begin
                loss_reg <= loss_next;
                diff_reg <= diff_next;
            end
            ST_MAG1:
            begin
                mag_reg <= MAG_W'(diff_abs);
                neg_reg <= diff_reg[DIFF_W-1];
            end
            ST_ML1, ST_ML2: plo_reg <= mul_p;
            ST_MH1, ST_MH2: phi_reg <= mul_p;
            ST_SUM1:  diss_reg  <= wide_sum[16 +: DISS_W];
            ST_NET:   net_reg   <= net_next;
            ST_MAG2:
            begin
                mag_reg <= MAG_W'(net_abs);
                neg_reg <= net_reg[NET_W-1];
            end
            ST_SUM2:  delta_reg <= wide_sum[MUL_W +: DELTA_W];
            ST_ACC:   sum_reg   <= sum_next;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= ACC_W'(AMBIENT_RESET) << F;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_FINISH) && slot_free)
            begin
                acc_reg       <= acc_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && slot_free)
        begin
            out_temp_reg <= acc_new[F +: TEMP_W];
            out_loss_reg <= (kind_reg == KIND_RESET) ? '0 : loss_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign winding_temperature = out_temp_reg;
    assign copper_loss_power   = out_loss_reg;

endmodule

`default_nettype wire

>>> hw/rtl/motor_winding_thermal_estimator.sv
// ----------------------------------------------------------------------------
// motor_winding_thermal_estimator
// First-order winding thermal model: copper loss and forward Euler update.
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  kind, phase_d/q_current, winding_resistance
// out       output     out_valid/out_stall  winding_temperature, copper_loss_power
// cfg       input      cfg_write            cfg_index, cfg_data
//
// an update request runs every back-end state, a reset request goes to finish
// directly; the single shared 32x32 multiplier is used five times per update
// a two-entry queue lets the front take requests while the back works
// result register lets the next request start while a result waits
// reset clears control state; temperature starts at the ambient reset value
// ----------------------------------------------------------------------------
`default_nettype none

module motor_winding_thermal_estimator
    import mwte_pkg::*;
#(
    parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  kind,
    input  wire logic [CUR_W-1:0]      phase_d_current,
    input  wire logic [CUR_W-1:0]      phase_q_current,
    input  wire logic [RES_W-1:0]      winding_resistance,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [TEMP_W-1:0]          winding_temperature,
    output logic [LOSS_W-1:0]          copper_loss_power
);

    cfg_t cfg_reg;
    cmd_t push_data;
    cmd_t pop_data;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ambient     <= AMBIENT_RESET;
            cfg_reg.conductance <= CONDUCTANCE_RESET;
            cfg_reg.gain        <= GAIN_RESET;
            cfg_reg.ceiling     <= CEILING_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_AMBIENT:     cfg_reg.ambient     <= cfg_data[AMB_W-1:0];
                REG_CONDUCTANCE: cfg_reg.conductance <= cfg_data[COND_W-1:0];
                REG_STEP_GAIN:   cfg_reg.gain        <= cfg_data[GAIN_W-1:0];
                REG_CEILING:     cfg_reg.ceiling     <= cfg_data[CEIL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mwte_front u_front
    (
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .phase_d_current    (phase_d_current),
        .phase_q_current    (phase_q_current),
        .winding_resistance (winding_resistance),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_data             (push_data)
    );

    mwte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_data),
        .pop     (q_pop),
        .rd_data (pop_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    mwte_core #(
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
    ) u_core
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .q_empty             (q_empty),
        .q_data              (pop_data),
        .q_pop               (q_pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .winding_temperature (winding_temperature),
        .copper_loss_power   (copper_loss_power)
    );

endmodule

`default_nettype wire

>>> bench/motor_winding_thermal_estimator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_winding_thermal_estimator_test
// Self-checking bench for the winding thermal estimator. A clocked driver
// feeds update and reset requests from a queue, with random gaps. A clocked
// monitor stalls the output at random and compares each result with a
// fixed-point copy of the copper loss and forward Euler step. The run covers
// register extremes, ambient above ceiling, loss saturation and random
// settings.
// ----------------------------------------------------------------------------
module motor_winding_thermal_estimator_test;
    import mwte_pkg::*;

    localparam int FRAC           = TEMP_FRAC_BITS_DEF;
    localparam int PHASE_REQUESTS = 153;
    localparam int PHASES         = 10;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct packed {
        logic              kind;
        logic [CUR_W-1:0]  id;
        logic [CUR_W-1:0]  iq;
        logic [RES_W-1:0]  rs;
    } request_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [LOSS_W-1:0] loss;
    } reading_t;

    logic                  clk                = 1'b0;
    logic                  rst_n              = 1'b0;
    logic                  cfg_write          = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index          = '0;
    logic [CFG_DATA_W-1:0] cfg_data           = '0;
    logic                  in_valid           = 1'b0;
    logic                  in_stall;
    logic                  kind               = KIND_UPDATE;
    logic [CUR_W-1:0]      phase_d_current    = '0;
    logic [CUR_W-1:0]      phase_q_current    = '0;
    logic [RES_W-1:0]      winding_resistance = '0;
    logic                  out_valid;
    logic                  out_stall          = 1'b0;
    logic [TEMP_W-1:0]     winding_temperature;
    logic [LOSS_W-1:0]     copper_loss_power;

    request_t pending_requests[$];
    reading_t expected_readings[$];
    int       mismatch_count = 0;
    bit       calm = 1'b0;

    // thermal state and register copies
    logic signed [AMB_W-1:0] ambient_q;
    logic [COND_W-1:0]       conductance_q;
    logic [GAIN_W-1:0]       gain_q;
    logic [CEIL_W-1:0]       ceiling_q;
    logic signed [63:0]      temp_acc;

    motor_winding_thermal_estimator u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .kind                (kind),
        .phase_d_current     (phase_d_current),
        .phase_q_current     (phase_q_current),
        .winding_resistance  (winding_resistance),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .winding_temperature (winding_temperature),
        .copper_loss_power   (copper_loss_power)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // signed times unsigned, shifted, magnitude truncated toward zero
    function automatic logic signed [63:0] scaled_product(
        input logic signed [63:0] a,
        input logic [31:0]        b,
        input int                 sh
    );
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] prod;
        neg  = a[63];
        mag  = neg ? -a : a;
        prod = {64'b0, mag} * {96'b0, b};
        prod = prod >> sh;
        return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
    endfunction

    function automatic reading_t advance_thermal_model(input request_t r);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic signed [63:0] id;
        logic signed [63:0] iq;
        logic signed [63:0] diss;
        logic signed [63:0] net_power;
        logic [63:0]        isq;
        logic [63:0]        loss;
        reading_t           res;
        lo = 64'(ambient_q);
        lo = lo <<< FRAC;
        hi = {48'b0, ceiling_q};
        hi = hi <<< FRAC;
        loss = '0;
        if (r.kind == KIND_RESET)
        begin
            temp_acc = lo;
        end
        else
        begin
            id   = 64'($signed(r.id));
            iq   = 64'($signed(r.iq));
            isq  = id * id + iq * iq;
            loss = (isq * {48'b0, r.rs}) >> LOSS_SHIFT;
            if (loss > {40'b0, LOSS_MAX})
                loss = {40'b0, LOSS_MAX};
            diss      = scaled_product(temp_acc - lo, {8'b0, conductance_q}, 16);
            net_power = $signed(loss << FRAC) - diss;
            temp_acc  = temp_acc + scaled_product(net_power, gain_q, 32);
            if (temp_acc < lo)
                temp_acc = lo;
            if (temp_acc > hi)
                temp_acc = hi;
        end
        res.temp = temp_acc[FRAC+TEMP_W-1:FRAC];
        res.loss = loss[LOSS_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // request driver
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        request_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                expected_readings.push_back(advance_thermal_model(request_t'(
                    {kind, phase_d_current, phase_q_current, winding_resistance})));
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                nxt = pending_requests.pop_front();
                in_valid           <= 1'b1;
                kind               <= nxt.kind;
                phase_d_current    <= nxt.id;
                phase_q_current    <= nxt.iq;
                winding_resistance <= nxt.rs;
                gap_left = pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch("unexpected result",
                                    64'({winding_temperature, copper_loss_power}), '0);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (winding_temperature !== want.temp)
                        report_mismatch("winding_temperature", 64'(winding_temperature),
                                        64'(want.temp));
                    if (copper_loss_power !== want.loss)
                        report_mismatch("copper_loss_power", 64'(copper_loss_power),
                                        64'(want.loss));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_AMBIENT:     ambient_q     = value[AMB_W-1:0];
            REG_CONDUCTANCE: conductance_q = value[COND_W-1:0];
            REG_STEP_GAIN:   gain_q        = value[GAIN_W-1:0];
            REG_CEILING:     ceiling_q     = value[CEIL_W-1:0];
            default: ;
        endcase
    endtask

    // upper bits of the narrow registers carry noise
    task automatic configure(input logic [AMB_W-1:0] amb, input logic [COND_W-1:0] cond,
                             input logic [GAIN_W-1:0] gain, input logic [CEIL_W-1:0] ceil);
        write_reg(REG_AMBIENT, {16'($urandom), amb});
        write_reg(REG_CONDUCTANCE, {8'($urandom), cond});
        write_reg(REG_STEP_GAIN, gain);
        write_reg(REG_CEILING, {16'($urandom), ceil});
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [CUR_W-1:0] random_current();
        logic [CUR_W-1:0] c;
        if ($urandom_range(0, 1) == 0)
            return CUR_W'($urandom);
        c = CUR_W'($urandom_range(0, 2047));
        return $urandom_range(0, 1) ? -c : c;
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.kind = ($urandom_range(0, 9) == 0) ? KIND_RESET : KIND_UPDATE;
        r.id   = random_current();
        r.iq   = random_current();
        r.rs   = ($urandom_range(0, 2) == 0) ? RES_W'($urandom_range(2048, 8192))
                                             : RES_W'($urandom);
        return r;
    endfunction

    task automatic queue_request(input logic k, input logic [CUR_W-1:0] d,
                                 input logic [CUR_W-1:0] q, input logic [RES_W-1:0] rs);
        pending_requests.push_back(request_t'({k, d, q, rs}));
    endtask

    initial
    begin
        int amb;
        int low_ceil;
        logic [GAIN_W-1:0] gain;
        logic [COND_W-1:0] cond;
        ambient_q     = AMBIENT_RESET;
        conductance_q = CONDUCTANCE_RESET;
        gain_q        = GAIN_RESET;
        ceiling_q     = CEILING_RESET;
        temp_acc      = 64'(ambient_q);
        temp_acc      = temp_acc <<< FRAC;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests at reset settings
        queue_request(KIND_UPDATE, 16'h0000, 16'h0000, 16'h0000);
        queue_request(KIND_UPDATE, 16'h7FFF, 16'h0000, 16'h1000);
        queue_request(KIND_UPDATE, 16'h8000, 16'h8000, 16'hFFFF);
        queue_request(KIND_UPDATE, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        queue_request(KIND_UPDATE, 16'h8000, 16'h7FFF, 16'h0001);
        queue_request(KIND_UPDATE, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_request(KIND_UPDATE, 16'h0100, 16'h0100, 16'h1000);
        queue_request(KIND_UPDATE, 16'h5555, 16'hAAAA, 16'h5555);
        queue_request(KIND_UPDATE, 16'hAAAA, 16'h5555, 16'hAAAA);
        queue_request(KIND_RESET,  16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_request(KIND_UPDATE, 16'h1000, 16'hF000, 16'h0000);
        queue_request(KIND_RESET,  16'h0000, 16'h0000, 16'h0000);
        queue_request(KIND_UPDATE, 16'h0001, 16'hFFFF, 16'h8000);
        drain();

        // ambient above ceiling with saturated loss
        configure(16'(32000), 24'hFFFFFF, 32'hFFFFFFFF, 16'd0);
        queue_request(KIND_UPDATE, 16'h8000, 16'h8000, 16'hFFFF);
        queue_request(KIND_UPDATE, 16'h0000, 16'h0000, 16'h0000);
        queue_request(KIND_RESET,  16'h1234, 16'h5678, 16'h9ABC);
        queue_request(KIND_UPDATE, 16'h0100, 16'h0200, 16'h1000);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            calm = (ph % 4 == 3);
            case (ph)
                0: configure(-16'sd10240, 24'd1, 32'hFFFFFFFF, 16'hFFFF);
                1: configure(16'(32000), 24'hFFFFFF, 32'hFFFFFFFF, 16'd0);
                2: configure(16'd6400, 24'd65536, 32'd0, 16'd51200);
                default:
                begin
                    amb = int'($urandom_range(0, 42240)) - 10240;
                    low_ceil = (amb < 0) ? 0 : amb;
                    case ($urandom_range(0, 3))
                        0:       gain = $urandom;
                        1:       gain = $urandom_range(0, 1 << 24);
                        2:       gain = $urandom_range(1 << 28, 32'h7FFFFFFF);
                        default: gain = GAIN_RESET;
                    endcase
                    cond = ($urandom_range(0, 1) == 0) ? COND_W'($urandom_range(1, 24'hFFFFFF))
                                                       : COND_W'($urandom_range(1, 1 << 18));
                    configure(16'(amb), cond, gain,
                              ($urandom_range(0, 4) == 0) ? CEIL_W'($urandom)
                                                          : CEIL_W'($urandom_range(low_ceil, 65535)));
                end
            endcase
            @(negedge clk);
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                // sender holds off until all results are in
                if (i == PHASE_REQUESTS / 2 && ph % 3 == 1)
                begin
                    drain();
                end
                pending_requests.push_back(random_request());
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
